>>> src/krt_pkg.sv
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef logic [3:0] req_code_t;
  typedef logic [2:0] status_t;
  typedef logic [IDX_W-1:0] slot_t;

  localparam req_code_t REQ_INSERT     = 4'd0;
  localparam req_code_t REQ_GET_ID     = 4'd1;
  localparam req_code_t REQ_GET_REMOVE = 4'd2;
  localparam req_code_t REQ_GET_POS    = 4'd3;
  localparam req_code_t REQ_GET_ENTRY  = 4'd4;
  localparam req_code_t REQ_ENQUEUED   = 4'd5;
  localparam req_code_t REQ_LOCK       = 4'd6;
  localparam req_code_t REQ_UNLOCK     = 4'd7;
  localparam req_code_t REQ_IS_LOCKED  = 4'd8;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_DUP       = 3'd1;
  localparam status_t ST_LOCKED    = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_FULL      = 3'd4;

  typedef struct packed {
    req_code_t   req_type;
    logic [63:0] record_id;
    logic [63:0] file_id_in;
    logic [62:0] position_in;
    logic        lock_on_insert;
    logic        override_lock;
  } req_word_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] file_id_out;
    logic [62:0] position_out;
    logic        lock_out;
    logic        answer;
  } rsp_word_t;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic        vld;
    req_code_t   req_type;
    logic [63:0] key;
    logic        ovr;
    logic        hit;
    slot_t       hit_idx;
    logic [63:0] fid;
    logic [62:0] pos;
    logic        locked;
    logic        free_found;
    slot_t       free_idx;
  } token_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_LOCK,
    CMD_UNLOCK
  } cmd_op_t;

  // Write-back broadcast to all cells; only the addressed slot acts.
  typedef struct packed {
    cmd_op_t     op;
    slot_t       idx;
    logic [63:0] key;
    logic [63:0] fid;
    logic [62:0] pos;
    logic        lock;
  } cmd_t;

endpackage

>>> src/keyed_record_table_with_locks.sv
// Keyed record table: one entry per cell, searched by a token that walks the cell row.
// The token passes every cell, is captured in S_DONE and waits there until the output register frees.
// A new request is accepted only after the previous response and write-back are registered;
// one request is in flight at a time.
// Reset clears every valid bit and the control state directly; no clearing pass.
module keyed_record_table_with_locks import krt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  token_t chain [TABLE_DEPTH+1];
  cmd_t   cmd;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (chain[0]),
    .tail      (chain[TABLE_DEPTH]),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    krt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (IDX_W'(i)),
      .tok_in  (chain[i]),
      .cmd     (cmd),
      .tok_out (chain[i+1])
    );
  end

endmodule

>>> src/krt_cell.sv
module krt_cell import krt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  slot_t  slot,
  input  token_t tok_in,
  input  cmd_t   cmd,
  output token_t tok_out
);

  logic        valid;
  logic [63:0] key;
  logic [63:0] fid;
  logic [62:0] pos;
  logic        locked;

  logic   match;
  logic   sel;
  token_t tok_next;

  assign match = valid && (key == tok_in.key);
  assign sel   = (cmd.idx == slot);

  always_comb begin
    tok_next = tok_in;
    // Keys are unique, so the first match is the only one.
    if (match && !tok_in.hit) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = slot;
      tok_next.fid     = fid;
      tok_next.pos     = pos;
      tok_next.locked  = locked;
    end
    // Claim the lowest free slot seen so far.
    if (!valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      unique case (cmd.op)
        CMD_INSERT: valid <= 1'b1;
        CMD_REMOVE: valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      unique case (cmd.op)
        CMD_INSERT: begin
          key    <= cmd.key;
          fid    <= cmd.fid;
          pos    <= cmd.pos;
          locked <= cmd.lock;
        end
        CMD_LOCK:   locked <= 1'b1;
        CMD_UNLOCK: locked <= 1'b0;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (sel && cmd.op == CMD_INSERT) |=> valid)
    else $error("inserted slot not marked valid");

  a_remove_clears_valid: assert property (@(posedge clk) disable iff (rst)
    (sel && cmd.op == CMD_REMOVE) |=> !valid)
    else $error("removed slot still valid");

  a_hit_kept: assert property (@(posedge clk) disable iff (rst)
    (tok_in.vld && tok_in.hit) |=> (tok_out.hit && tok_out.hit_idx == $past(tok_in.hit_idx)))
    else $error("earlier hit overwritten by later cell");
`endif

endmodule

>>> src/krt_ctrl.sv
module krt_ctrl import krt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp,
  output token_t    head,
  input  token_t    tail,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t      state;
  token_t      fin;
  logic [63:0] ins_fid;
  logic [62:0] ins_pos;
  logic        ins_lock;

  rsp_word_t   res;
  cmd_t        res_cmd;
  logic        rsp_free;
  logic        emit;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign emit      = (state == S_DONE) && rsp_free;

  always_comb begin
    res          = '0;
    res_cmd      = '0;
    res_cmd.op   = CMD_NONE;
    res_cmd.key  = fin.key;
    res_cmd.fid  = ins_fid;
    res_cmd.pos  = ins_pos;
    res_cmd.lock = ins_lock;
    res_cmd.idx  = fin.hit_idx;
    case (fin.req_type) inside
      REQ_INSERT: begin
        if (fin.hit) begin
          res.status = ST_DUP;
        end else if (!fin.free_found) begin
          res.status = ST_FULL;
        end else begin
          res_cmd.op  = CMD_INSERT;
          res_cmd.idx = fin.free_idx;
        end
      end
      REQ_GET_ID, REQ_GET_POS: begin
        if (!fin.hit) begin
          res.status = ST_NOT_FOUND;
        end else if (fin.locked) begin
          res.status = ST_LOCKED;
        end else if (fin.req_type == REQ_GET_ID) begin
          res.file_id_out = fin.fid;
        end else begin
          res.position_out = fin.pos;
        end
      end
      REQ_GET_REMOVE: begin
        if (!fin.hit) begin
          res.status = ST_NOT_FOUND;
        end else if (fin.locked && !fin.ovr) begin
          res.status = ST_LOCKED;
        end else begin
          res.file_id_out = fin.fid;
          res_cmd.op      = CMD_REMOVE;
        end
      end
      REQ_GET_ENTRY: begin
        if (!fin.hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.file_id_out  = fin.fid;
          res.position_out = fin.pos;
          res.lock_out     = fin.locked;
        end
      end
      REQ_ENQUEUED: begin
        res.answer = fin.hit && (fin.ovr || !fin.locked);
      end
      REQ_LOCK, REQ_UNLOCK: begin
        if (!fin.hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res_cmd.op = (fin.req_type == REQ_LOCK) ? CMD_LOCK : CMD_UNLOCK;
        end
      end
      REQ_IS_LOCKED: begin
        if (!fin.hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.answer = fin.locked;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      head.vld  <= 1'b0;
      cmd.op    <= CMD_NONE;
    end else begin
      head.vld <= (state == S_IDLE) && req_valid;
      // Hold the finished search until the output register frees up.
      if (emit) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
        cmd       <= res_cmd;
      end else begin
        cmd.op <= CMD_NONE;
        if (rsp_ready) begin
          rsp_valid <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            head.req_type   <= req.req_type;
            head.key        <= req.record_id;
            head.ovr        <= req.override_lock;
            head.hit        <= 1'b0;
            head.hit_idx    <= '0;
            head.fid        <= '0;
            head.pos        <= '0;
            head.locked     <= 1'b0;
            head.free_found <= 1'b0;
            head.free_idx   <= '0;
            ins_fid         <= req.file_id_in;
            ins_pos         <= req.position_in;
            ins_lock        <= req.lock_on_insert;
            state           <= S_RUN;
          end
        end
        S_RUN: begin
          if (tail.vld) begin
            fin   <= tail;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cmd_pulse: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != CMD_NONE) |=> (cmd.op == CMD_NONE))
    else $error("write-back held longer than one cycle");

  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> (state == S_RUN))
    else $error("search token arrived outside of a search");

  a_accept_injects: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (head.vld && state == S_RUN))
    else $error("accepted word did not start a search");
`endif

endmodule
